// File: rtl/utfd_pkg.sv
// Shared types, codes and constants of the byte stream Unicode decoder.
package utfd_pkg;

   // Widths of the word fields.
   localparam int unsigned BYTE_W = 8;
   localparam int unsigned CP_W   = 21;
   localparam int unsigned ACC_W  = 26;
   localparam int unsigned UNIT_W = 16;
   localparam int unsigned SURR_W = 10;

   // Depth of the result queue behind the decoder.
   localparam int unsigned RSP_QUEUE_DEPTH = 4;

   // Fixed code points.
   localparam logic [CP_W-1:0] REPLACEMENT_CP = CP_W'(24'h00FFFD);
   localparam logic [CP_W-1:0] SUPPLEMENTARY_BASE = CP_W'(24'h010000);

   // Surrogate unit prefixes (top six bits of a 16-bit unit).
   localparam logic [5:0] HIGH_SURR_PREFIX = 6'b110110;
   localparam logic [5:0] LOW_SURR_PREFIX  = 6'b110111;

   // Encoding selected by the mode register.
   typedef enum logic [1:0] {
      MODE_UTF8    = 2'd0,
      MODE_UTF16BE = 2'd1,
      MODE_UTF16LE = 2'd2,
      MODE_RAW     = 2'd3
   } mode_type;

   // One input word.
   typedef struct packed {
      logic [BYTE_W-1:0] data_byte;
      logic              end_of_input;
   } req_type;

   // One result word.
   typedef struct packed {
      logic [CP_W-1:0] code_point;
      logic            malformed;
      logic            stream_end;
      logic            last_of_run;
   } rsp_type;

   // Results of one decoded input word, handed from decoder to queue.
   typedef struct packed {
      logic [1:0] count;
      rsp_type    first;
      rsp_type    second;
   } dec_out_type;

   // Sum of the lead and continuation marker bits folded into a UTF-8 sequence.
   function automatic logic [ACC_W-1:0] utf8_offset(input logic [1:0] extra);
      logic [ACC_W-1:0] offset;
      begin
         case (extra)
            2'd1:    offset = ACC_W'(32'h0000_3080);
            2'd2:    offset = ACC_W'(32'h000E_2080);
            2'd3:    offset = ACC_W'(32'h03C8_2080);
            default: offset = '0;
         endcase
         return offset;
      end
   endfunction

endpackage

// File: rtl/utf_byte_stream_decoder.sv
// Top level of the byte stream Unicode decoder.
//
// Input words (req_) carry one stream byte or an end-of-input marker; result
// words (rsp_) carry one code point each, with flags for replacement, stream
// end and last result of its input word. Both channels use valid/ready.
// The csr_ port writes the two-bit encoding mode (UTF-8, UTF-16BE, UTF-16LE,
// raw); a write also drops any half-decoded sequence. An accepted word is
// held in the input register and decoded straight out of it; its results
// are written into a small result queue once the queue has room, and the
// queue offers them on rsp_. One input word is taken every cycle as long
// as the queue has room for two results; the queue drains one result per
// cycle while the receiver is ready, so words that give two results slow
// intake to the output rate. When the receiver stalls, the queue fills and
// req_ready falls. Reset empties the input register and the queue, clears
// the decoder state and selects UTF-8.
module utf_byte_stream_decoder #(
   parameter int unsigned RSP_DEPTH = utfd_pkg::RSP_QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  utfd_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output utfd_pkg::rsp_type rsp_data,
   input  logic              csr_wr_en,
   input  logic [1:0]        csr_wr_data
);
   import utfd_pkg::*;

   logic        in_valid_ff, in_valid_in;
   req_type     in_item_ff;
   logic        room;
   logic        advance;
   dec_out_type dec_out;

   assign advance     = in_valid_ff && room;
   assign req_ready   = !in_valid_ff || advance;
   assign in_valid_in = (req_valid && req_ready) || (in_valid_ff && !advance);

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_item_ff <= req_data;
      end
   end

   // Decode stage with the decoder state.
   utfd_decode u_decode (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .fire        (advance),
      .item        (in_item_ff),
      .dec_out     (dec_out)
   );

   // Result queue.
   utfd_rsp_queue #(
      .DEPTH (RSP_DEPTH)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (advance),
      .dec_out   (dec_out),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// File: rtl/utfd_decode.sv
// Decoder state and the single-pass decode of one registered input word.
module utfd_decode (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [1:0]            csr_wr_data,
   input  logic                  fire,
   input  utfd_pkg::req_type     item,
   output utfd_pkg::dec_out_type dec_out
);
   import utfd_pkg::*;

   mode_type            mode_ff, mode_in;
   logic [ACC_W-1:0]    acc_ff, acc_in;
   logic [1:0]          left_ff, left_in;
   logic [1:0]          extra_ff, extra_in;
   logic [1:0]          phase_ff, phase_in;
   logic [SURR_W-1:0]   first_ff, first_in;
   logic [BYTE_W-1:0]   partial_ff, partial_in;

   logic [BYTE_W-1:0]   b;
   logic [UNIT_W-1:0]   unit;
   logic [ACC_W-1:0]    acc_sum;
   logic                open_seq;
   logic                a_emit, b_emit;
   rsp_type             res_a, res_b;

   assign b = item.data_byte;

   // Decode: up to two results (a then b) and the next decoder state.
   always_comb begin
      mode_in    = mode_ff;
      acc_in     = acc_ff;
      left_in    = left_ff;
      extra_in   = extra_ff;
      phase_in   = phase_ff;
      first_in   = first_ff;
      partial_in = partial_ff;
      a_emit     = 1'b0;
      b_emit     = 1'b0;
      res_a      = '0;
      res_b      = '0;
      unit       = (mode_ff == MODE_UTF16BE) ? {partial_ff, b} : {b, partial_ff};
      acc_sum    = {acc_ff[ACC_W-7:0], 6'b0} + ACC_W'(b);
      open_seq   = ((mode_ff == MODE_UTF8) && (left_ff != 2'd0)) ||
                   (((mode_ff == MODE_UTF16BE) || (mode_ff == MODE_UTF16LE)) &&
                    (phase_ff != 2'd0));

      if (csr_wr_en) begin
         // A mode write drops any half-read sequence.
         mode_in    = mode_type'(csr_wr_data);
         acc_in     = '0;
         left_in    = '0;
         extra_in   = '0;
         phase_in   = '0;
         first_in   = '0;
         partial_in = '0;
      end else if (fire) begin
         if (item.end_of_input) begin
            // End of stream: flag an open sequence, then report the end.
            a_emit               = open_seq;
            res_a.code_point     = REPLACEMENT_CP;
            res_a.malformed      = 1'b1;
            b_emit               = 1'b1;
            res_b.stream_end     = 1'b1;
            acc_in     = '0;
            left_in    = '0;
            extra_in   = '0;
            phase_in   = '0;
            first_in   = '0;
            partial_in = '0;
         end else begin
            unique case (mode_ff)
               MODE_UTF8: begin
                  if ((left_ff != 2'd0) && (b[7:6] == 2'b10)) begin
                     // Continuation byte: fold it in, finish on the last one.
                     acc_in  = acc_sum;
                     left_in = left_ff - 2'd1;
                     if (left_ff == 2'd1) begin
                        a_emit           = 1'b1;
                        res_a.code_point = CP_W'(acc_sum - utf8_offset(extra_ff));
                        acc_in           = '0;
                        extra_in         = '0;
                     end
                  end else begin
                     // Bad continuation gives a replacement, then the byte
                     // is taken again as a lead byte.
                     if (left_ff != 2'd0) begin
                        a_emit           = 1'b1;
                        res_a.code_point = REPLACEMENT_CP;
                        res_a.malformed  = 1'b1;
                        acc_in           = '0;
                        left_in          = '0;
                        extra_in         = '0;
                     end
                     if (b < 8'hC0) begin
                        b_emit           = 1'b1;
                        res_b.code_point = CP_W'(b);
                     end else if (b >= 8'hF8) begin
                        b_emit           = 1'b1;
                        res_b.code_point = REPLACEMENT_CP;
                        res_b.malformed  = 1'b1;
                     end else begin
                        acc_in   = ACC_W'(b);
                        left_in  = (b < 8'hE0) ? 2'd1 : (b < 8'hF0) ? 2'd2 : 2'd3;
                        extra_in = (b < 8'hE0) ? 2'd1 : (b < 8'hF0) ? 2'd2 : 2'd3;
                     end
                  end
               end
               MODE_UTF16BE, MODE_UTF16LE: begin
                  if (!phase_ff[0]) begin
                     // First byte of a unit.
                     partial_in = b;
                     phase_in   = phase_ff + 2'd1;
                  end else if (phase_ff == 2'd1) begin
                     // Second byte of a unit with no high surrogate pending.
                     phase_in = 2'd0;
                     if (unit[15:10] == HIGH_SURR_PREFIX) begin
                        first_in = unit[SURR_W-1:0];
                        phase_in = 2'd2;
                     end else if (unit[15:10] == LOW_SURR_PREFIX) begin
                        a_emit           = 1'b1;
                        res_a.code_point = REPLACEMENT_CP;
                        res_a.malformed  = 1'b1;
                     end else begin
                        a_emit           = 1'b1;
                        res_a.code_point = CP_W'(unit);
                     end
                  end else begin
                     // Second unit after a high surrogate.
                     phase_in = 2'd0;
                     first_in = '0;
                     a_emit   = 1'b1;
                     if (unit[15:10] == LOW_SURR_PREFIX) begin
                        res_a.code_point = SUPPLEMENTARY_BASE +
                                           CP_W'({first_ff, unit[SURR_W-1:0]});
                     end else begin
                        res_a.code_point = REPLACEMENT_CP;
                        res_a.malformed  = 1'b1;
                        b_emit           = 1'b1;
                        res_b.code_point = CP_W'(unit);
                     end
                  end
               end
               MODE_RAW: begin
                  a_emit           = 1'b1;
                  res_a.code_point = CP_W'(b);
               end
               default: begin
                  a_emit = 1'b0;
               end
            endcase
         end
      end
   end

   // Pack the emitted results in order and mark the last one.
   always_comb begin
      dec_out.count  = 2'(a_emit) + 2'(b_emit);
      dec_out.first  = a_emit ? res_a : res_b;
      dec_out.second = res_b;
      dec_out.first.last_of_run  = !(a_emit && b_emit);
      dec_out.second.last_of_run = 1'b1;
   end

   // Decoder state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_UTF8;
         acc_ff     <= '0;
         left_ff    <= '0;
         extra_ff   <= '0;
         phase_ff   <= '0;
         first_ff   <= '0;
         partial_ff <= '0;
      end else begin
         mode_ff    <= mode_in;
         acc_ff     <= acc_in;
         left_ff    <= left_in;
         extra_ff   <= extra_in;
         phase_ff   <= phase_in;
         first_ff   <= first_in;
         partial_ff <= partial_in;
      end
   end

endmodule

// File: rtl/utfd_rsp_queue.sv
// Result queue: takes up to two result words a cycle, hands out one while the receiver is ready.
module utfd_rsp_queue #(
   parameter int unsigned DEPTH = utfd_pkg::RSP_QUEUE_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  utfd_pkg::dec_out_type dec_out,
   output logic                  room,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output utfd_pkg::rsp_type     rsp_data
);
   import utfd_pkg::*;

   localparam int unsigned PW = (DEPTH > 2) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);

   rsp_type        entry_ff [DEPTH];
   logic [PW-1:0]  wr_ptr_ff, wr_ptr_in, wr_ptr_nx;
   logic [PW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]  count_ff, count_in;
   logic [1:0]     push_count;
   logic           pop;

   function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] ptr);
      begin
         return (ptr == PW'(DEPTH - 1)) ? '0 : ptr + PW'(1);
      end
   endfunction

   assign pop        = rsp_valid && rsp_ready;
   assign push_count = push ? dec_out.count : 2'd0;
   assign wr_ptr_nx  = wrap_inc(wr_ptr_ff);
   assign rsp_valid  = (count_ff != '0);
   assign rsp_data   = entry_ff[rd_ptr_ff];

   // Space for two words once this cycle's pop is counted.
   assign room = ((CW+1)'(count_ff) + (CW+1)'(2)) <= ((CW+1)'(DEPTH) + (CW+1)'(pop));

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      if (push_count == 2'd1) begin
         wr_ptr_in = wr_ptr_nx;
      end else if (push_count == 2'd2) begin
         wr_ptr_in = wrap_inc(wr_ptr_nx);
      end
      rd_ptr_in = pop ? wrap_inc(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + CW'(push_count) - CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage.
   always_ff @(posedge clock) begin
      if (push_count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= dec_out.first;
      end
      if (push_count == 2'd2) begin
         entry_ff[wr_ptr_nx] <= dec_out.second;
      end
   end

endmodule

// File: rtl/utfd_checker.sv
// Port-level checks of the decoder, bound to the top level.
module utfd_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input utfd_pkg::rsp_type rsp_data
);
   import utfd_pkg::*;

   // A stalled result word holds until taken.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result word changed or dropped while stalled");

   // Reset leaves no result pending and the input side open.
   assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("block not empty after reset");

   // A replacement always carries U+FFFD.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.malformed |->
         rsp_data.code_point == REPLACEMENT_CP && !rsp_data.stream_end)
      else $error("malformed result without replacement character");

   // The end report is a clean zero and closes its run.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.stream_end |->
         rsp_data.code_point == '0 && !rsp_data.malformed && rsp_data.last_of_run)
      else $error("bad end-of-stream result");

endmodule

bind utf_byte_stream_decoder utfd_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

// File: tb/sv/tb_utf_byte_stream_decoder.sv
`timescale 1ns / 1ps
// Self-checking testbench of the byte stream Unicode decoder, with its own decoding model.
module tb_utf_byte_stream_decoder;
   import utfd_pkg::*;

   localparam int unsigned QUIET_LIMIT     = 2000;
   localparam int unsigned SETTLE_CYCLES   = 8;
   localparam int unsigned WORDS_PER_BLOCK = 140;

   logic       clock       = 1'b0;
   logic       reset       = 1'b1;
   logic       req_valid   = 1'b0;
   logic       req_ready;
   req_type    req_data    = '0;
   logic       rsp_valid;
   logic       rsp_ready   = 1'b0;
   rsp_type    rsp_data;
   logic       csr_wr_en   = 1'b0;
   logic [1:0] csr_wr_data = '0;

   int unsigned sender_idle_pct    = 0;
   int unsigned receiver_stall_pct = 0;
   int unsigned error_count        = 0;
   int unsigned words_sent         = 0;

   // Code points still owed by the decoder, oldest first, and those of the current word.
   rsp_type expected_chars[$];
   rsp_type run_chars[$];

   // Model copy of the mode register and of the decoding state.
   mode_type    cur_mode   = MODE_UTF8;
   logic [25:0] utf8_acc   = '0;
   logic [1:0]  utf8_left  = '0;
   logic [1:0]  utf8_extra = '0;
   logic [1:0]  u16_phase  = '0;
   logic [15:0] u16_high   = '0;
   logic [7:0]  u16_byte   = '0;

   utf_byte_stream_decoder u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // Free-running clock, 10 ns period.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // The receiver stalls at random at the current rate.
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   // Each accepted result word is compared with the oldest expected one.
   always @(posedge clock) begin : check_results
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_chars.size() == 0) begin
            $display("%0t: unexpected result, expected none, got cp=%h mal=%b end=%b last=%b",
                     $time, rsp_data.code_point, rsp_data.malformed, rsp_data.stream_end,
                     rsp_data.last_of_run);
            error_count++;
         end else begin
            want = expected_chars.pop_front();
            if (rsp_data.code_point !== want.code_point) begin
               $display("%0t: code_point expected %h, got %h",
                        $time, want.code_point, rsp_data.code_point);
               error_count++;
            end
            if (rsp_data.malformed !== want.malformed) begin
               $display("%0t: malformed expected %b, got %b",
                        $time, want.malformed, rsp_data.malformed);
               error_count++;
            end
            if (rsp_data.stream_end !== want.stream_end) begin
               $display("%0t: stream_end expected %b, got %b",
                        $time, want.stream_end, rsp_data.stream_end);
               error_count++;
            end
            if (rsp_data.last_of_run !== want.last_of_run) begin
               $display("%0t: last_of_run expected %b, got %b",
                        $time, want.last_of_run, rsp_data.last_of_run);
               error_count++;
            end
         end
      end
   end

   // The run ends in failure when no word moves on either channel for too long.
   initial begin : watchdog
      int unsigned quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
      end
      $display("tb_utf_byte_stream_decoder failed");
      $finish;
   end

   // Model: one result of the current word.
   function automatic void add_char(input logic [20:0] cp, input logic bad, input logic fin);
      rsp_type r;
      r.code_point  = cp;
      r.malformed   = bad;
      r.stream_end  = fin;
      r.last_of_run = 1'b0;
      run_chars.push_back(r);
   endfunction

   function automatic void clear_decoder();
      utf8_acc   = '0;
      utf8_left  = '0;
      utf8_extra = '0;
      u16_phase  = '0;
      u16_high   = '0;
      u16_byte   = '0;
   endfunction

   // Model: a UTF-8 byte seen outside a sequence.
   function automatic void utf8_take_lead(input logic [7:0] b);
      if (b < 8'hC0) begin
         add_char(21'(b), 1'b0, 1'b0);
      end else if (b >= 8'hF8) begin
         add_char(REPLACEMENT_CP, 1'b1, 1'b0);
      end else begin
         utf8_extra = (b < 8'hE0) ? 2'd1 : (b < 8'hF0) ? 2'd2 : 2'd3;
         utf8_acc   = 26'(b);
         utf8_left  = utf8_extra;
      end
   endfunction

   // Model: any UTF-8 byte. The marker bits of lead and continuations are
   // subtracted once the sequence is complete.
   function automatic void utf8_take_byte(input logic [7:0] b);
      logic [25:0] marks;
      if (utf8_left == 2'd0) begin
         utf8_take_lead(b);
      end else if (b < 8'h80 || b >= 8'hC0) begin
         utf8_acc   = '0;
         utf8_left  = '0;
         utf8_extra = '0;
         add_char(REPLACEMENT_CP, 1'b1, 1'b0);
         utf8_take_lead(b);
      end else begin
         utf8_acc = (utf8_acc << 6) + 26'(b);
         utf8_left--;
         if (utf8_left == 2'd0) begin
            case (utf8_extra)
               2'd1: begin
                  marks = 26'h000_3080;
               end
               2'd2: begin
                  marks = 26'h00E_2080;
               end
               default: begin
                  marks = 26'h3C8_2080;
               end
            endcase
            add_char(21'(utf8_acc - marks), 1'b0, 1'b0);
            utf8_acc   = '0;
            utf8_extra = '0;
         end
      end
   endfunction

   // Model: a UTF-16 byte; phases 0 and 1 gather a unit, 2 and 3 the unit after a high surrogate.
   function automatic void utf16_take_byte(input logic [7:0] b);
      logic [15:0] unit;
      if (u16_phase == 2'd0 || u16_phase == 2'd2) begin
         u16_byte = b;
         u16_phase++;
      end else begin
         unit = (cur_mode == MODE_UTF16BE) ? {u16_byte, b} : {b, u16_byte};
         if (u16_phase == 2'd1) begin
            u16_phase = 2'd0;
            if (unit[15:10] == HIGH_SURR_PREFIX) begin
               u16_high  = unit;
               u16_phase = 2'd2;
            end else if (unit[15:10] == LOW_SURR_PREFIX) begin
               add_char(REPLACEMENT_CP, 1'b1, 1'b0);
            end else begin
               add_char(21'(unit), 1'b0, 1'b0);
            end
         end else begin
            u16_phase = 2'd0;
            if (unit[15:10] == LOW_SURR_PREFIX) begin
               add_char(SUPPLEMENTARY_BASE + 21'({u16_high[9:0], unit[9:0]}), 1'b0, 1'b0);
            end else begin
               add_char(REPLACEMENT_CP, 1'b1, 1'b0);
               add_char(21'(unit), 1'b0, 1'b0);
            end
            u16_high = '0;
         end
      end
   endfunction

   // Model: all results of one accepted input word, appended to the expected ones.
   function automatic void predict_word(input req_type w);
      rsp_type r;
      run_chars.delete();
      if (w.end_of_input) begin
         if ((cur_mode == MODE_UTF8 && utf8_left != 2'd0) ||
             ((cur_mode == MODE_UTF16BE || cur_mode == MODE_UTF16LE) && u16_phase != 2'd0)) begin
            add_char(REPLACEMENT_CP, 1'b1, 1'b0);
         end
         add_char('0, 1'b0, 1'b1);
         clear_decoder();
      end else begin
         case (cur_mode)
            MODE_UTF8: begin
               utf8_take_byte(w.data_byte);
            end
            MODE_UTF16BE, MODE_UTF16LE: begin
               utf16_take_byte(w.data_byte);
            end
            default: begin
               add_char(21'(w.data_byte), 1'b0, 1'b0);
            end
         endcase
      end
      if (run_chars.size() > 0) begin
         r = run_chars.pop_back();
         r.last_of_run = 1'b1;
         run_chars.push_back(r);
      end
      foreach (run_chars[i]) begin
         expected_chars.push_back(run_chars[i]);
      end
   endfunction

   // Offers one word after a random idle gap and waits until it is taken.
   // Called and left at a falling edge; valid stays high for a following word.
   task automatic send_word(input logic [7:0] b, input logic fin);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= {b, fin};
      @(posedge clock);
      while (req_ready !== 1'b1) begin
         @(posedge clock);
      end
      predict_word(req_data);
      words_sent++;
      @(negedge clock);
   endtask

   task automatic send_byte(input logic [7:0] b);
      send_word(b, 1'b0);
   endtask

   // The byte of an end marker is random, since it is ignored.
   task automatic send_end();
      send_word(8'($urandom_range(255)), 1'b1);
   endtask

   task automatic send_unit(input logic [15:0] u);
      if (cur_mode == MODE_UTF16BE) begin
         send_byte(u[15:8]);
         send_byte(u[7:0]);
      end else begin
         send_byte(u[7:0]);
         send_byte(u[15:8]);
      end
   endtask

   // Stops sending until every expected result is in and the decoder has gone quiet.
   task automatic drain();
      req_valid <= 1'b0;
      @(negedge clock);
      while (expected_chars.size() != 0) begin
         @(negedge clock);
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Mode writes happen only with the decoder idle; they also drop any open sequence.
   task automatic write_mode(input mode_type m);
      drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= m;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      cur_mode = m;
      clear_decoder();
      @(negedge clock);
   endtask

   task automatic set_idling(input int unsigned phase);
      case (phase)
         0: begin
            sender_idle_pct    = 0;
            receiver_stall_pct = 0;
         end
         1: begin
            sender_idle_pct    = 46;
            receiver_stall_pct = 0;
         end
         2: begin
            sender_idle_pct    = 0;
            receiver_stall_pct = 46;
         end
         default: begin
            sender_idle_pct    = 6;
            receiver_stall_pct = 6;
         end
      endcase
   endtask

   // UTF-8 right after reset: stand-alone and unused leads, the largest
   // four-byte value, a bad continuation that is itself a lead, and end
   // inside a sequence.
   task automatic test_utf8_directed();
      send_byte(8'hBF);
      send_byte(8'hFF);
      send_byte(8'hF7);
      send_byte(8'hBF);
      send_byte(8'hBF);
      send_byte(8'hBF);
      send_byte(8'hC3);
      send_byte(8'hC3);
      send_byte(8'hA9);
      send_byte(8'hE2);
      send_byte(8'h82);
      send_end();
   endtask

   // UTF-16: the largest pair, a lone low surrogate, a high surrogate
   // followed by a plain unit, and end inside a unit.
   task automatic test_utf16_directed();
      write_mode(MODE_UTF16BE);
      send_unit(16'hDBFF);
      send_unit(16'hDFFF);
      send_unit(16'hDC00);
      write_mode(MODE_UTF16LE);
      send_unit(16'hD800);
      send_unit(16'h0041);
      send_byte(8'hFF);
      send_end();
   endtask

   // Raw bytes pass through unchanged.
   task automatic test_raw_directed();
      write_mode(MODE_RAW);
      send_byte(8'hFF);
      send_byte(8'h00);
      send_end();
   endtask

   // A mode write drops a half-read sequence without a result.
   task automatic test_mode_write_drop();
      write_mode(MODE_UTF8);
      send_byte(8'hE2);
      write_mode(MODE_UTF8);
      send_byte(8'h41);
      write_mode(MODE_UTF16BE);
      send_byte(8'hD8);
      write_mode(MODE_UTF16BE);
      send_unit(16'h00E9);
   endtask

   // Mostly well-formed UTF-8 sequences, some cut short, plus stray bytes and end markers.
   task automatic send_utf8_random();
      int unsigned pick;
      int unsigned n_extra;
      logic [7:0]  lead;
      pick = $urandom_range(99);
      if (pick < 75) begin
         n_extra = $urandom_range(3);
         case (n_extra)
            0: begin
               lead = 8'($urandom_range(8'h7F));
            end
            1: begin
               lead = 8'($urandom_range(8'hDF, 8'hC0));
            end
            2: begin
               lead = 8'($urandom_range(8'hEF, 8'hE0));
            end
            default: begin
               lead = 8'($urandom_range(8'hF7, 8'hF0));
            end
         endcase
         send_byte(lead);
         repeat (n_extra) send_byte(8'($urandom_range(8'hBF, 8'h80)));
      end else if (pick < 87) begin
         send_byte(8'($urandom_range(8'hF7, 8'hC0)));
         repeat ($urandom_range(2)) send_byte(8'($urandom_range(8'hBF, 8'h80)));
         send_byte(8'($urandom_range(255)));
      end else if (pick < 97) begin
         send_byte(8'($urandom_range(255)));
      end else begin
         send_end();
      end
   endtask

   // Random units, proper surrogate pairs, stray bytes that shift the unit
   // alignment, and end markers.
   task automatic send_utf16_random();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 50) begin
         send_unit(16'($urandom_range(16'hFFFF)));
      end else if (pick < 85) begin
         send_unit(16'($urandom_range(16'hDBFF, 16'hD800)));
         send_unit(16'($urandom_range(16'hDFFF, 16'hDC00)));
      end else if (pick < 95) begin
         send_byte(8'($urandom_range(255)));
      end else begin
         send_end();
      end
   endtask

   // Random blocks, one mode and one idling pattern each; the sender pauses
   // for a full drain halfway through every block.
   task automatic test_random_streams();
      mode_type    plan [8];
      int unsigned stop_at;
      plan = '{MODE_RAW, MODE_UTF8, MODE_UTF16BE, MODE_UTF16LE,
               MODE_UTF8, MODE_UTF16LE, MODE_UTF16BE, MODE_UTF8};
      for (int blk = 0; blk < 8; blk++) begin
         write_mode(plan[blk]);
         set_idling(blk % 4);
         repeat (2) begin
            stop_at = words_sent + WORDS_PER_BLOCK / 2;
            while (words_sent < stop_at) begin
               case (cur_mode)
                  MODE_UTF8: begin
                     send_utf8_random();
                  end
                  MODE_UTF16BE, MODE_UTF16LE: begin
                     send_utf16_random();
                  end
                  default: begin
                     if ($urandom_range(99) < 5) begin
                        send_end();
                     end else begin
                        send_byte(8'($urandom_range(255)));
                     end
                  end
               endcase
            end
            drain();
         end
      end
   endtask

   // Reset, then the tests in turn, then the verdict.
   initial begin
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_utf8_directed();
      test_utf16_directed();
      test_raw_directed();
      test_mode_write_drop();
      test_random_streams();
      drain();
      if (error_count == 0 && expected_chars.size() == 0) begin
         $display("tb_utf_byte_stream_decoder passed");
      end else begin
         $display("tb_utf_byte_stream_decoder failed");
      end
      $finish;
   end

endmodule

// File: files.f
rtl/utfd_pkg.sv
rtl/utfd_decode.sv
rtl/utfd_rsp_queue.sv
rtl/utf_byte_stream_decoder.sv
rtl/utfd_checker.sv
tb/sv/tb_utf_byte_stream_decoder.sv
